/* design/fct_pkg.sv */
// Shared types, codes and plane tables of the frustum culling unit.
package fct_pkg;

  localparam int unsigned PlaneCount = 6;

  typedef enum logic [2:0] {
    CMD_LOAD   = 3'd0,
    CMD_BUILD  = 3'd1,
    CMD_POINT  = 3'd2,
    CMD_SPHERE = 3'd3,
    CMD_CUBE   = 3'd4
  } cmd_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DONE,
    ST_B_RD_BASE,
    ST_B_RD_OTHER,
    ST_B_CAP,
    ST_B_HALF,
    ST_B_SQ,
    ST_B_SQACC,
    ST_B_ROOT_GO,
    ST_B_ROOT,
    ST_B_DIV_GO,
    ST_B_DIV,
    ST_B_WR,
    ST_Q_RD,
    ST_Q_MUL,
    ST_Q_ACC,
    ST_Q_EMUL,
    ST_Q_EACC,
    ST_Q_TEST
  } state_e;

  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } fct_ctl_t;

  // Matrix row combined with row 3 for each plane.
  function automatic logic [1:0] plane_row(input logic [2:0] p);
    case (p)
      3'd0, 3'd1: plane_row = 2'd0;
      3'd2, 3'd3: plane_row = 2'd1;
      default:    plane_row = 2'd2;
    endcase
  endfunction

  // Planes built as row3 + rowk; the others use row3 - rowk.
  function automatic logic plane_add(input logic [2:0] p);
    case (p)
      3'd1, 3'd2, 3'd5: plane_add = 1'b1;
      default:          plane_add = 1'b0;
    endcase
  endfunction

endpackage

/* design/fct_sqdiv.sv */
// Iterative unit: 64-bit integer square root or 50-by-32-bit restoring division.
module fct_sqdiv (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fct_pkg::fct_ctl_t ctl_i,
  input  logic [63:0]       rad_i,
  input  logic [49:0]       num_i,
  input  logic [31:0]       den_i,
  output logic              done_o,
  output logic [31:0]       root_o,
  output logic [49:0]       quot_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic        sqrt_q, sqrt_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] n_q, n_d;
  logic [63:0] r_q, r_d;
  logic [63:0] bit_q, bit_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic [49:0] num_q, num_d;
  logic [63:0] trial;
  logic [32:0] rem_sh;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    sqrt_d = sqrt_q;
    cnt_d  = cnt_q;
    n_d    = n_q;
    r_d    = r_q;
    bit_d  = bit_q;
    rem_d  = rem_q;
    den_d  = den_q;
    num_d  = num_q;
    trial  = r_q + bit_q;
    rem_sh = {rem_q, num_q[49]};
    if (ctl_i.start) begin
      busy_d = 1'b1;
      sqrt_d = ctl_i.sqrt_mode;
      n_d    = rad_i;
      r_d    = '0;
      bit_d  = 64'h4000_0000_0000_0000;
      rem_d  = '0;
      den_d  = den_i;
      num_d  = num_i;
      cnt_d  = ctl_i.sqrt_mode ? 6'd31 : 6'd49;
    end else if (busy_q) begin
      if (sqrt_q) begin
        if (n_q >= trial) begin
          n_d = n_q - trial;
          r_d = (r_q >> 1) + bit_q;
        end else begin
          r_d = r_q >> 1;
        end
        bit_d = bit_q >> 2;
      end else begin
        if (rem_sh >= {1'b0, den_q}) begin
          rem_d = 32'(rem_sh - {1'b0, den_q});
          num_d = {num_q[48:0], 1'b1};
        end else begin
          rem_d = rem_sh[31:0];
          num_d = {num_q[48:0], 1'b0};
        end
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      sqrt_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      sqrt_q <= sqrt_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    r_q   <= r_d;
    bit_q <= bit_d;
    rem_q <= rem_d;
    den_q <= den_d;
    num_q <= num_d;
  end

  assign done_o = done_q;
  assign root_o = r_q[31:0];
  assign quot_o = num_q;

endmodule

/* design/frustum_cull_tester_unit.sv */
// Top level of the frustum culling unit: command sequencer, matrix and plane memories, MAC.
//
// One command is taken at a time. In a query, each plane's four components are read one by
// one from the plane memory and go through a single registered multiplier and accumulator,
// and a cube adds three extent products per plane. A build does, per plane, eight matrix
// reads, three squares, a 32-step square root and four 50-step divisions (none when the
// root is zero) in the shared iterative root/divide unit. Results wait in an output register
// while the next command is already accepted.
module frustum_cull_tester_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // matrix_index[3:0], matrix_value[35:4], pos_x[67:36], pos_y[99:68], pos_z[131:100],
  // extent[163:132], zero fill[167:164]
  input  logic [167:0] s_axis_tdata,
  // command[2:0]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // visible[0], bad_plane[1], zero fill[7:2]
  output logic [7:0]   m_axis_tdata
);

  fct_pkg::state_e state_q, state_d;

  logic [3:0]  in_idx;
  logic [31:0] in_mval, in_x, in_y, in_z, in_e;

  logic [31:0] mat_mem [16];
  logic [15:0] mat_vld_q;
  logic [3:0]  mat_raddr;
  logic [31:0] mat_rdata_q;
  logic        mat_rvld_q;
  logic [31:0] mat_data;
  logic        mat_we;

  logic [31:0] pl_mem [24];
  logic [23:0] pl_vld_q;
  logic [4:0]  pl_raddr;
  logic [31:0] pl_rdata_q;
  logic        pl_rvld_q;
  logic [31:0] pl_data;
  logic        pl_we;
  logic [4:0]  pl_waddr;
  logic [31:0] pl_wdata;

  logic [2:0]  p_q, p_d;
  logic [1:0]  j_q, j_d;
  logic [2:0]  cmd_q, cmd_d;
  logic [31:0] x_q, x_d, y_q, y_d, z_q, z_d, e_q, e_d;
  logic signed [67:0] acc_q, acc_d;
  logic        vis_q, vis_d, bad_q, bad_d, zero_q, zero_d;
  logic [33:0] raw_q [4];
  logic [33:0] raw_d [4];
  logic [31:0] base_q, base_d;
  logic [63:0] sum_q, sum_d;
  logic [31:0] mag_q, mag_d;
  logic [31:0] comp_q, comp_d;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_q;
  logic        out_valid_q, out_valid_d, out_vis_q, out_vis_d, out_bad_q, out_bad_d;
  logic        big;
  logic [33:0] raw_abs;
  logic [33:0] raw_sext_base, raw_sext_other;

  fct_pkg::fct_ctl_t ctl;
  logic [63:0] sd_rad;
  logic [49:0] sd_num;
  logic        sd_done;
  logic [31:0] sd_root;
  logic [49:0] sd_quot;

  function automatic logic [32:0] abs33(input logic [31:0] v);
    logic [32:0] s;
    s = {v[31], v};
    abs33 = v[31] ? 33'(-s) : s;
  endfunction

  function automatic logic [33:0] abs34(input logic [33:0] v);
    abs34 = v[33] ? 34'(-v) : v;
  endfunction

  assign in_idx  = s_axis_tdata[3:0];
  assign in_mval = s_axis_tdata[35:4];
  assign in_x    = s_axis_tdata[67:36];
  assign in_y    = s_axis_tdata[99:68];
  assign in_z    = s_axis_tdata[131:100];
  assign in_e    = s_axis_tdata[163:132];

  assign s_axis_tready = (state_q == fct_pkg::ST_IDLE);
  assign mat_we = s_axis_tvalid && s_axis_tready && (s_axis_tuser == fct_pkg::CMD_LOAD);
  assign mat_data = mat_rvld_q ? mat_rdata_q : '0;
  assign pl_data  = pl_rvld_q ? pl_rdata_q : '0;
  assign raw_abs  = abs34(raw_q[j_q]);
  assign sd_rad   = sum_q;
  assign sd_num   = {1'b0, raw_abs[32:0], 16'b0} + {19'b0, mag_q[31:1]};
  assign raw_sext_base  = {{2{base_q[31]}}, base_q};
  assign raw_sext_other = {{2{mat_data[31]}}, mat_data};

  always_comb begin
    big = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (abs34(raw_q[k]) >= 34'h0_8000_0000) big = 1'b1;
    end
  end

  always_comb begin
    state_d     = state_q;
    p_d         = p_q;
    j_d         = j_q;
    cmd_d       = cmd_q;
    x_d         = x_q;
    y_d         = y_q;
    z_d         = z_q;
    e_d         = e_q;
    acc_d       = acc_q;
    vis_d       = vis_q;
    bad_d       = bad_q;
    zero_d      = zero_q;
    raw_d       = raw_q;
    base_d      = base_q;
    sum_d       = sum_q;
    mag_d       = mag_q;
    comp_d      = comp_q;
    mat_raddr   = '0;
    pl_raddr    = {p_q, j_q};
    pl_we       = 1'b0;
    pl_waddr    = {p_q, j_q};
    pl_wdata    = zero_q ? '0 : comp_q;
    mul_a       = '0;
    mul_b       = '0;
    ctl         = '0;
    out_valid_d = out_valid_q;
    out_vis_d   = out_vis_q;
    out_bad_d   = out_bad_q;
    if (m_axis_tvalid && m_axis_tready) out_valid_d = 1'b0;

    case (state_q)
      fct_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d = s_axis_tuser;
          x_d   = in_x;
          y_d   = in_y;
          z_d   = in_z;
          e_d   = in_e;
          acc_d = (s_axis_tuser == fct_pkg::CMD_SPHERE) ?
                  {{20{in_e[31]}}, in_e, 16'b0} : '0;
          p_d   = '0;
          j_d   = '0;
          vis_d = 1'b0;
          bad_d = 1'b0;
          case (s_axis_tuser)
            fct_pkg::CMD_BUILD: state_d = fct_pkg::ST_B_RD_BASE;
            fct_pkg::CMD_POINT, fct_pkg::CMD_SPHERE, fct_pkg::CMD_CUBE: begin
              vis_d   = 1'b1;
              state_d = fct_pkg::ST_Q_RD;
            end
            default: state_d = fct_pkg::ST_DONE;
          endcase
        end
      end
      fct_pkg::ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_vis_d   = vis_q;
          out_bad_d   = bad_q;
          state_d     = fct_pkg::ST_IDLE;
        end
      end
      fct_pkg::ST_B_RD_BASE: begin
        mat_raddr = {2'd3, j_q};
        state_d   = fct_pkg::ST_B_RD_OTHER;
      end
      fct_pkg::ST_B_RD_OTHER: begin
        mat_raddr = {fct_pkg::plane_row(p_q), j_q};
        base_d    = mat_data;
        state_d   = fct_pkg::ST_B_CAP;
      end
      fct_pkg::ST_B_CAP: begin
        raw_d[j_q] = fct_pkg::plane_add(p_q) ? raw_sext_base + raw_sext_other
                                             : raw_sext_base - raw_sext_other;
        j_d = j_q + 2'd1;
        state_d = (j_q == 2'd3) ? fct_pkg::ST_B_HALF : fct_pkg::ST_B_RD_BASE;
      end
      fct_pkg::ST_B_HALF: begin
        if (big) begin
          for (int k = 0; k < 4; k++) begin
            raw_d[k] = 34'($signed(raw_q[k] + {33'b0, raw_q[k][33]}) >>> 1);
          end
        end
        sum_d   = '0;
        j_d     = '0;
        state_d = fct_pkg::ST_B_SQ;
      end
      fct_pkg::ST_B_SQ: begin
        mul_a   = raw_abs[32:0];
        mul_b   = raw_abs[32:0];
        state_d = fct_pkg::ST_B_SQACC;
      end
      fct_pkg::ST_B_SQACC: begin
        sum_d = sum_q + prod_q[63:0];
        if (j_q == 2'd2) begin
          j_d     = '0;
          state_d = fct_pkg::ST_B_ROOT_GO;
        end else begin
          j_d     = j_q + 2'd1;
          state_d = fct_pkg::ST_B_SQ;
        end
      end
      fct_pkg::ST_B_ROOT_GO: begin
        ctl.start     = 1'b1;
        ctl.sqrt_mode = 1'b1;
        state_d       = fct_pkg::ST_B_ROOT;
      end
      fct_pkg::ST_B_ROOT: begin
        if (sd_done) begin
          mag_d  = sd_root;
          zero_d = (sd_root == '0);
          if (sd_root == '0) begin
            bad_d   = 1'b1;
            state_d = fct_pkg::ST_B_WR;
          end else begin
            state_d = fct_pkg::ST_B_DIV_GO;
          end
        end
      end
      fct_pkg::ST_B_DIV_GO: begin
        ctl.start = 1'b1;
        state_d   = fct_pkg::ST_B_DIV;
      end
      fct_pkg::ST_B_DIV: begin
        if (sd_done) begin
          if (raw_q[j_q][33]) begin
            comp_d = (sd_quot >= 50'h0_8000_0000) ? 32'h8000_0000 : 32'(-sd_quot[31:0]);
          end else begin
            comp_d = (sd_quot >= 50'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : sd_quot[31:0];
          end
          state_d = fct_pkg::ST_B_WR;
        end
      end
      fct_pkg::ST_B_WR: begin
        pl_we = 1'b1;
        j_d   = j_q + 2'd1;
        if (j_q == 2'd3) begin
          p_d     = p_q + 3'd1;
          state_d = (p_q == 3'(fct_pkg::PlaneCount - 1)) ? fct_pkg::ST_DONE
                                                          : fct_pkg::ST_B_RD_BASE;
        end else begin
          state_d = zero_q ? fct_pkg::ST_B_WR : fct_pkg::ST_B_DIV_GO;
        end
      end
      fct_pkg::ST_Q_RD: begin
        state_d = fct_pkg::ST_Q_MUL;
      end
      fct_pkg::ST_Q_MUL: begin
        comp_d = pl_data;
        mul_a  = {pl_data[31], pl_data};
        case (j_q)
          2'd0:    mul_b = {x_q[31], x_q};
          2'd1:    mul_b = {y_q[31], y_q};
          2'd2:    mul_b = {z_q[31], z_q};
          default: mul_b = 33'sd65536;
        endcase
        state_d = fct_pkg::ST_Q_ACC;
      end
      fct_pkg::ST_Q_ACC: begin
        acc_d = acc_q + {{2{prod_q[65]}}, prod_q};
        if (cmd_q == fct_pkg::CMD_CUBE && j_q != 2'd3) begin
          state_d = fct_pkg::ST_Q_EMUL;
        end else if (j_q == 2'd3) begin
          state_d = fct_pkg::ST_Q_TEST;
        end else begin
          j_d     = j_q + 2'd1;
          state_d = fct_pkg::ST_Q_RD;
        end
      end
      fct_pkg::ST_Q_EMUL: begin
        mul_a   = abs33(comp_q);
        mul_b   = abs33(e_q);
        state_d = fct_pkg::ST_Q_EACC;
      end
      fct_pkg::ST_Q_EACC: begin
        acc_d   = acc_q + {{2{prod_q[65]}}, prod_q};
        j_d     = j_q + 2'd1;
        state_d = fct_pkg::ST_Q_RD;
      end
      fct_pkg::ST_Q_TEST: begin
        if (!(acc_q > 0)) vis_d = 1'b0;
        acc_d = (cmd_q == fct_pkg::CMD_SPHERE) ? {{20{e_q[31]}}, e_q, 16'b0} : '0;
        j_d   = '0;
        p_d   = p_q + 3'd1;
        state_d = (p_q == 3'(fct_pkg::PlaneCount - 1)) ? fct_pkg::ST_DONE
                                                        : fct_pkg::ST_Q_RD;
      end
      default: state_d = fct_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fct_pkg::ST_IDLE;
      mat_vld_q   <= '0;
      pl_vld_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (mat_we) mat_vld_q[in_idx] <= 1'b1;
      if (pl_we) pl_vld_q[pl_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mat_we) mat_mem[in_idx] <= in_mval;
    mat_rdata_q <= mat_mem[mat_raddr];
    mat_rvld_q  <= mat_vld_q[mat_raddr];
    if (pl_we) pl_mem[pl_waddr] <= pl_wdata;
    pl_rdata_q <= pl_mem[pl_raddr];
    pl_rvld_q  <= pl_vld_q[pl_raddr];
  end

  always_ff @(posedge clk_i) begin
    p_q       <= p_d;
    j_q       <= j_d;
    cmd_q     <= cmd_d;
    x_q       <= x_d;
    y_q       <= y_d;
    z_q       <= z_d;
    e_q       <= e_d;
    acc_q     <= acc_d;
    vis_q     <= vis_d;
    bad_q     <= bad_d;
    zero_q    <= zero_d;
    raw_q     <= raw_d;
    base_q    <= base_d;
    sum_q     <= sum_d;
    mag_q     <= mag_d;
    comp_q    <= comp_d;
    prod_q    <= mul_a * mul_b;
    out_vis_q <= out_vis_d;
    out_bad_q <= out_bad_d;
  end

  fct_sqdiv u_sqdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .rad_i  (sd_rad),
    .num_i  (sd_num),
    .den_i  (mag_q),
    .done_o (sd_done),
    .root_o (sd_root),
    .quot_o (sd_quot)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_bad_q, out_vis_q};

endmodule

/* design/fct_checker.sv */
// Port-level checker of the frustum culling unit, bound to the top level.
module fct_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [7:0]   m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again before the command was worked");

  a_fill_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:2] == 6'b0)
    else $error("output fill bits not zero");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("visible and bad_plane raised together");

endmodule

bind frustum_cull_tester_unit fct_checker u_fct_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* dv/frustum_cull_checker.sv */
// Frustum culling checker: predicts each result from accepted input beats and compares.
module frustum_cull_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [167:0] s_axis_tdata,
  input  logic [2:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [7:0]   m_axis_tdata,
  output int           fail_count_o,
  output int           pending_o
);

  typedef struct packed {
    logic visible;
    logic bad_plane;
  } cull_res_t;

  logic signed [31:0] mat_q[16];
  logic signed [31:0] plane_q[24];
  cull_res_t          cull_exp_q[$];

  assign pending_o = cull_exp_q.size();

  function automatic logic [63:0] isqrt(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] norm_comp(input logic signed [63:0] v,
                                                   input logic [63:0] m);
    logic [63:0] av;
    logic [63:0] q;
    av = v < 0 ? -v : v;
    q = (av * 64'd65536 + m / 2) / m;
    if (v < 0) return q >= 64'h8000_0000 ? 32'sh8000_0000 : -q[31:0];
    return q >= 64'h7fff_ffff ? 32'sh7fff_ffff : q[31:0];
  endfunction

  function automatic logic rebuild_planes();
    logic bad;
    logic signed [63:0] raw[4];
    logic [63:0] sum;
    logic [63:0] m;
    logic [63:0] av;
    logic big;
    bad = 1'b0;
    for (int p = 0; p < 6; p++) begin
      big = 1'b0;
      sum = 0;
      for (int j = 0; j < 4; j++) begin
        if (p inside {1, 2, 5})
          raw[j] = 64'(mat_q[12+j]) + 64'(mat_q[(p/2)*4+j]);
        else
          raw[j] = 64'(mat_q[12+j]) - 64'(mat_q[(p/2)*4+j]);
        av = raw[j] < 0 ? -raw[j] : raw[j];
        if (j < 3 && av >= 64'h8000_0000) big = 1'b1;
      end
      if (big) for (int j = 0; j < 4; j++) raw[j] = raw[j] / 2;
      for (int j = 0; j < 3; j++) begin
        av = raw[j] < 0 ? -raw[j] : raw[j];
        sum += av * av;
      end
      m = isqrt(sum);
      for (int j = 0; j < 4; j++)
        plane_q[p*4+j] = (m == 0) ? 32'sd0 : norm_comp(raw[j], m);
      if (m == 0) bad = 1'b1;
    end
    return bad;
  endfunction

  function automatic logic signed [127:0] plane_dist(input int p,
                                                     input logic signed [127:0] x,
                                                     input logic signed [127:0] y,
                                                     input logic signed [127:0] z);
    return 128'(plane_q[p*4]) * x + 128'(plane_q[p*4+1]) * y
         + 128'(plane_q[p*4+2]) * z + 128'(plane_q[p*4+3]) * 65536;
  endfunction

  function automatic cull_res_t predict_cull(input logic [2:0] cmd, input logic [167:0] d);
    cull_res_t r;
    logic signed [127:0] x, y, z, e;
    logic any_in;
    r = '0;
    x = 128'($signed(d[67:36]));
    y = 128'($signed(d[99:68]));
    z = 128'($signed(d[131:100]));
    e = 128'($signed(d[163:132]));
    if (cmd == fct_pkg::CMD_LOAD) begin
      mat_q[d[3:0]] = d[35:4];
    end else if (cmd == fct_pkg::CMD_BUILD) begin
      r.bad_plane = rebuild_planes();
    end else if (cmd inside {fct_pkg::CMD_POINT, fct_pkg::CMD_SPHERE, fct_pkg::CMD_CUBE})
    begin
      r.visible = 1'b1;
      for (int p = 0; p < 6; p++) begin
        if (cmd == fct_pkg::CMD_POINT) begin
          if (plane_dist(p, x, y, z) <= 0) r.visible = 1'b0;
        end else if (cmd == fct_pkg::CMD_SPHERE) begin
          if (plane_dist(p, x, y, z) <= -e * 65536) r.visible = 1'b0;
        end else begin
          any_in = 1'b0;
          for (int k = 0; k < 8; k++)
            if (plane_dist(p, k[0] ? x + e : x - e, k[1] ? y + e : y - e,
                           k[2] ? z + e : z - e) > 0) any_in = 1'b1;
          if (!any_in) r.visible = 1'b0;
        end
      end
    end
    return r;
  endfunction

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    foreach (mat_q[i]) mat_q[i] = '0;
    foreach (plane_q[i]) plane_q[i] = '0;
  end

  always @(posedge clk_i) begin
    cull_res_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (cull_exp_q.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          want = cull_exp_q.pop_front();
          if (m_axis_tdata[0] !== want.visible)
            report($sformatf("visible %b, want %b", m_axis_tdata[0], want.visible));
          if (m_axis_tdata[1] !== want.bad_plane)
            report($sformatf("bad_plane %b, want %b", m_axis_tdata[1], want.bad_plane));
          if (m_axis_tdata[7:2] !== 6'd0) report("nonzero fill bits");
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        cull_exp_q.push_back(predict_cull(s_axis_tuser, s_axis_tdata));
    end
  end

endmodule

/* dv/frustum_cull_tester_unit_tb.sv */
// Testbench top for the frustum culling unit: stimulus, flow control and verdict.
module frustum_cull_tester_unit_tb;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [167:0] s_axis_tdata;
  logic [2:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [7:0]   m_axis_tdata;
  int           fail_count;
  int           pending;
  logic         stall_heavy;

  frustum_cull_tester_unit u_top (.*);

  frustum_cull_checker u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  initial begin
    #200000000;
    $display("frustum_cull_tester_unit regression: fail");
    $finish;
  end

  initial stall_heavy = 1'b0;
  always @(posedge clk_i) begin
    if ($urandom_range(0, 299) == 0) stall_heavy <= ~stall_heavy;
    m_axis_tready <= stall_heavy ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 7) != 0);
  end

  int burst_left;

  function automatic logic [31:0] pick_val();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return $urandom;
      default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  task automatic send(input logic [2:0] cmd, input logic [3:0] idx, input logic [31:0] v,
                      input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                      input logic [31:0] e);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {4'd0, e, z, y, x, v, idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
  endtask

  task automatic send_query(input logic [2:0] cmd);
    send(cmd, 4'($urandom), $urandom, pick_val(), pick_val(), pick_val(), pick_val());
  endtask

  task automatic load_matrix(input int kind);
    logic [31:0] v;
    for (int i = 0; i < 16; i++) begin
      case (kind)
        0: v = (i % 5 == 0) ? 32'h0001_0000 : 32'h0;
        1: v = $urandom;
        2: v = (i < 12) ? 32'h8000_0000 : 32'h7fff_ffff;
        3: v = 32'h0;
        default: v = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      endcase
      send(fct_pkg::CMD_LOAD, 4'(i), v, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    int sent;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = fct_pkg::CMD_LOAD;
    m_axis_tready = 1'b0;
    burst_left = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send(fct_pkg::CMD_POINT, 0, 0, 0, 0, 0, 0);
    send(fct_pkg::CMD_CUBE, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 0, 32'h7fff_ffff);
    send(fct_pkg::CMD_BUILD, 0, 0, 0, 0, 0, 0);
    load_matrix(0);
    send(fct_pkg::CMD_BUILD, 0, 0, 0, 0, 0, 0);
    send(fct_pkg::CMD_POINT, 0, 0, 0, 0, 0, 0);
    send(fct_pkg::CMD_SPHERE, 0, 0, 32'h0002_0000, 0, 0, 32'h0001_8000);
    send(fct_pkg::CMD_SPHERE, 0, 0, 0, 0, 0, 32'hffff_0000);
    send(fct_pkg::CMD_CUBE, 0, 0, 32'h0003_0000, 0, 0, 32'h0002_0000);
    send(3'd5, 4'hf, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send(3'd7, 0, 0, 0, 0, 0, 0);
    load_matrix(2);
    send(fct_pkg::CMD_BUILD, 0, 0, 0, 0, 0, 0);
    send(fct_pkg::CMD_SPHERE, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
         32'h8000_0000);
    sent = 0;
    while (sent < 1950) begin
      if ($urandom_range(0, 3) != 0) begin
        load_matrix($urandom_range(0, 4));
        send(fct_pkg::CMD_BUILD, 0, 0, 0, 0, 0, 0);
        sent += 17;
        repeat ($urandom_range(5, 30)) begin
          send_query(3'(fct_pkg::CMD_POINT + $urandom_range(0, 2)));
          sent++;
        end
      end else begin
        repeat ($urandom_range(1, 10)) begin
          case ($urandom_range(0, 9))
            0: send(fct_pkg::CMD_LOAD, 4'($urandom), pick_val(), $urandom, $urandom,
                    $urandom, $urandom);
            1: send(fct_pkg::CMD_BUILD, 0, 0, 0, 0, 0, 0);
            2: send_query(3'($urandom_range(5, 7)));
            default: send_query(3'(fct_pkg::CMD_POINT + $urandom_range(0, 2)));
          endcase
          sent++;
        end
      end
    end
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (2000) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("frustum_cull_tester_unit regression: pass");
    end else begin
      $display("frustum_cull_tester_unit regression: fail");
    end
    $finish;
  end

endmodule
